// ===== rtl/prwl_pkg.sv =====
// Package: shared types, codes and default sizes for the reversed-word lookup block.
`default_nettype none
package prwl_pkg;

    localparam int DEF_MAX_WORDS = 1024;
    localparam int DEF_MAX_LEN   = 32;

    localparam logic [1:0] ACT_DICT   = 2'd0;
    localparam logic [1:0] ACT_QUERY  = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_byte;
        logic       word_end;
    } item_t;

    typedef struct packed {
        logic is_palindrome;
        logic is_semordnilap;
        logic dictionary_overflowed;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAL   = 5'b00010,
        ST_PROBE = 5'b00100,
        ST_CMP   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/palindrome_reverse_word_lookup.sv =====
// Top level: byte-serial dictionary store with palindrome and reversed-word search.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+---------------------------------
//  item     | in  | item_valid / item_stall      | action, char_byte, word_end
//  result   | out | result_valid / result_stall  | palindrome, semordnilap, overflow
//
// A dictionary byte, a clear or a query byte without word_end is taken in the idle state.
// A query end starts a palindrome scan of the query and, when the word is no palindrome
// and the dictionary is not empty, a search of up to log2(words)+1 probes, each comparing
// up to min(len,qlen) bytes; the single read port of the dictionary byte memory sets the probe pace.
// Reset clears counters, flags and the sequencer; the memories are not cleared and
// need none, since only written entries are read. The block holds item_stall high
// while a search runs, and waits in its final state while the result register is
// still full and stalled.
`default_nettype none
module palindrome_reverse_word_lookup
    import prwl_pkg::*;
#(
    parameter int MAX_WORDS = DEF_MAX_WORDS,
    parameter int MAX_LEN   = DEF_MAX_LEN
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_stall,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result
);

    localparam int WIDX_W     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CNT_W      = $clog2(MAX_WORDS + 1);
    localparam int POS_W      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W      = $clog2(MAX_LEN + 1);
    localparam int IDX_W      = LEN_W + 1;
    localparam int SW         = CNT_W + 1;
    localparam int DICT_DEPTH = MAX_WORDS * (1 << POS_W);
    localparam int DADDR_W    = WIDX_W + POS_W;

    // Memories
    logic [7:0]       dict_mem [DICT_DEPTH];
    logic [LEN_W-1:0] len_mem  [MAX_WORDS];
    logic [7:0]       q_mem    [MAX_LEN];

    logic [7:0]       dict_rd_reg;
    logic [LEN_W-1:0] len_rd_reg;
    logic [7:0]       qa_rd_reg;
    logic [7:0]       qb_rd_reg;

    // Control state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [LEN_W-1:0]   load_pos_reg, load_pos_next;
    logic [LEN_W-1:0]   query_pos_reg, query_pos_next;
    logic               flag_reg, flag_next;
    logic [LEN_W-1:0]   qlen_reg, qlen_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   cidx_reg, cidx_next;
    logic               dv_reg, dv_next;
    logic signed [SW-1:0] left_reg, left_next;
    logic signed [SW-1:0] right_reg, right_next;
    logic [WIDX_W-1:0]  mid_reg, mid_next;
    logic               pal_reg, pal_next;
    logic               sem_reg, sem_next;
    result_t            out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    // Write side
    logic               dict_we;
    logic [DADDR_W-1:0] dict_waddr;
    logic               len_we;
    logic [LEN_W-1:0]   len_wdata;
    logic               q_we;

    logic               accept;
    logic [IDX_W-1:0]   rev_idx;
    logic [DADDR_W-1:0] dict_raddr;
    logic [LEN_W-1:0]   n_cmp;
    logic [SW:0]        mid_sum;
    logic [LEN_W-1:0]   new_pos;

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Reads run every cycle off the registered search indices.
    assign rev_idx    = IDX_W'(qlen_reg) - IDX_W'(1) - i_reg;
    assign dict_raddr = {mid_reg, i_reg[POS_W-1:0]};
    assign dict_waddr = {total_reg[WIDX_W-1:0], load_pos_reg[POS_W-1:0]};
    assign n_cmp      = (len_rd_reg < qlen_reg) ? len_rd_reg : qlen_reg;
    assign mid_sum    = {left_reg[SW-1], left_reg} + {right_reg[SW-1], right_reg};
    assign new_pos    = load_pos_reg + LEN_W'(1);

    always_ff @(posedge clk)
    begin
        if (dict_we)
        begin
            dict_mem[dict_waddr] <= item.char_byte;
        end
        dict_rd_reg <= dict_mem[dict_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[total_reg[WIDX_W-1:0]] <= len_wdata;
        end
        len_rd_reg <= len_mem[mid_reg];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[query_pos_reg[POS_W-1:0]] <= item.char_byte;
        end
        qa_rd_reg <= q_mem[i_reg[POS_W-1:0]];
        qb_rd_reg <= q_mem[rev_idx[POS_W-1:0]];
    end

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        load_pos_next  = load_pos_reg;
        query_pos_next = query_pos_reg;
        flag_next      = flag_reg;
        qlen_next      = qlen_reg;
        i_next         = i_reg;
        cidx_next      = cidx_reg;
        dv_next        = dv_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        mid_next       = mid_reg;
        pal_next       = pal_reg;
        sem_next       = sem_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        dict_we        = 1'b0;
        len_we         = 1'b0;
        len_wdata      = load_pos_reg;
        q_we           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.action)
                        ACT_DICT:
                        begin
                            if (total_reg == CNT_W'(MAX_WORDS))
                            begin
                                // Full: drop the byte, flag a lost word at its end.
                                if (item.word_end)
                                begin
                                    flag_next = 1'b1;
                                end
                            end
                            else
                            begin
                                if (load_pos_reg < LEN_W'(MAX_LEN))
                                begin
                                    dict_we       = 1'b1;
                                    load_pos_next = new_pos;
                                    len_wdata     = new_pos;
                                end
                                if (item.word_end)
                                begin
                                    len_we        = 1'b1;
                                    total_next    = total_reg + CNT_W'(1);
                                    load_pos_next = '0;
                                end
                            end
                        end
                        ACT_QUERY:
                        begin
                            qlen_next = query_pos_reg;
                            if (query_pos_reg < LEN_W'(MAX_LEN))
                            begin
                                q_we           = 1'b1;
                                query_pos_next = query_pos_reg + LEN_W'(1);
                                qlen_next      = query_pos_reg + LEN_W'(1);
                            end
                            if (item.word_end)
                            begin
                                query_pos_next = '0;
                                i_next         = '0;
                                dv_next        = 1'b0;
                                sem_next       = 1'b0;
                                state_next     = ST_PAL;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            total_next    = '0;
                            load_pos_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_PAL:
            begin
                i_next    = i_reg + IDX_W'(1);
                cidx_next = i_reg;
                dv_next   = 1'b1;
                if (dv_reg)
                begin
                    if (cidx_reg >= IDX_W'(qlen_reg) || qa_rd_reg != qb_rd_reg)
                    begin
                        pal_next = (cidx_reg >= IDX_W'(qlen_reg));
                        if (cidx_reg >= IDX_W'(qlen_reg) || total_reg == '0)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            left_next  = '0;
                            right_next = $signed({1'b0, total_reg}) - SW'(1);
                            state_next = ST_PROBE;
                        end
                    end
                end
            end

            ST_PROBE:
            begin
                if (left_reg > right_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mid_next   = mid_sum[WIDX_W:1];
                    i_next     = '0;
                    dv_next    = 1'b0;
                    state_next = ST_CMP;
                end
            end

            ST_CMP:
            begin
                i_next    = i_reg + IDX_W'(1);
                cidx_next = i_reg;
                dv_next   = 1'b1;
                if (dv_reg)
                begin
                    if (cidx_reg >= IDX_W'(n_cmp))
                    begin
                        // Common prefix exhausted: order by length.
                        if (len_rd_reg == qlen_reg)
                        begin
                            sem_next   = 1'b1;
                            state_next = ST_DONE;
                        end
                        else if (len_rd_reg < qlen_reg)
                        begin
                            left_next  = $signed({1'b0, CNT_W'(mid_reg)}) + SW'(1);
                            state_next = ST_PROBE;
                        end
                        else
                        begin
                            right_next = $signed({1'b0, CNT_W'(mid_reg)}) - SW'(1);
                            state_next = ST_PROBE;
                        end
                    end
                    else if (dict_rd_reg != qb_rd_reg)
                    begin
                        if (dict_rd_reg < qb_rd_reg)
                        begin
                            left_next = $signed({1'b0, CNT_W'(mid_reg)}) + SW'(1);
                        end
                        else
                        begin
                            right_next = $signed({1'b0, CNT_W'(mid_reg)}) - SW'(1);
                        end
                        state_next = ST_PROBE;
                    end
                end
            end

            ST_DONE:
            begin
                // Hold until the result register is free.
                if (!out_valid_reg || !result_stall)
                begin
                    out_next.is_palindrome         = pal_reg;
                    out_next.is_semordnilap        = sem_reg && !pal_reg;
                    out_next.dictionary_overflowed = flag_reg;
                    out_valid_next                 = 1'b1;
                    state_next                     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            load_pos_reg  <= '0;
            query_pos_reg <= '0;
            flag_reg      <= 1'b0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            load_pos_reg  <= load_pos_next;
            query_pos_reg <= query_pos_next;
            flag_reg      <= flag_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qlen_reg  <= qlen_next;
        i_reg     <= i_next;
        cidx_reg  <= cidx_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        mid_reg   <= mid_next;
        pal_reg   <= pal_next;
        sem_reg   <= sem_next;
        out_reg   <= out_next;
    end

`ifndef SYNTH
    // A new result appears only out of the final search state.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside final state");

    // Dictionary state does not move while a search runs.
    a_dict_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> ($stable(total_reg) && $stable(flag_reg)))
        else $error("dictionary changed during search");

    // A stalled, full result register is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_stall) |=> (out_valid_reg && $stable(out_reg)))
        else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_palindrome_reverse_word_lookup.sv =====
// Testbench for the palindrome and reversed-word dictionary lookup block.
`default_nettype none

class lookup_scoreboard;
    // predictor copy of the block state
    byte unsigned word_store[1024][32];
    int           word_len[1024];
    int           stored_total;
    int           load_pos;
    byte unsigned query_buf[32];
    int           query_pos;
    bit           overflowed;
    prwl_pkg::result_t pending[$];
    int errors;
    int results_seen;
    int palindromes_seen;
    int semordnilaps_seen;

    function new();
        stored_total = 0;
        load_pos = 0;
        query_pos = 0;
        overflowed = 0;
        errors = 0;
        results_seen = 0;
        palindromes_seen = 0;
        semordnilaps_seen = 0;
    endfunction

    function int compare_word(int idx, byte unsigned rev[32], int qlen);
        int n;
        n = (word_len[idx] < qlen) ? word_len[idx] : qlen;
        for (int i = 0; i < n; i++)
            if (word_store[idx][i] != rev[i])
                return (word_store[idx][i] < rev[i]) ? -1 : 1;
        if (word_len[idx] == qlen)
            return 0;
        return (word_len[idx] < qlen) ? -1 : 1;
    endfunction

    function bit find_reversal(byte unsigned rev[32], int qlen);
        int lo;
        int hi;
        int mid;
        int c;
        lo = 0;
        hi = stored_total - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            c = compare_word(mid, rev, qlen);
            if (c == 0)
                return 1;
            if (c > 0)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return 0;
    endfunction

    function void note_item(prwl_pkg::item_t it);
        byte unsigned rev[32];
        prwl_pkg::result_t r;
        int qlen;
        bit pal;
        case (it.action)
            prwl_pkg::ACT_DICT:
            begin
                if (stored_total >= 1024)
                begin
                    if (it.word_end)
                        overflowed = 1;
                end
                else
                begin
                    if (load_pos < 32)
                    begin
                        word_store[stored_total][load_pos] = it.char_byte;
                        load_pos++;
                    end
                    if (it.word_end)
                    begin
                        word_len[stored_total] = load_pos;
                        stored_total++;
                        load_pos = 0;
                    end
                end
            end
            prwl_pkg::ACT_QUERY:
            begin
                if (query_pos < 32)
                begin
                    query_buf[query_pos] = it.char_byte;
                    query_pos++;
                end
                if (it.word_end)
                begin
                    qlen = query_pos;
                    pal = 1;
                    for (int i = 0; i < qlen; i++)
                    begin
                        rev[i] = query_buf[qlen - 1 - i];
                        if (rev[i] != query_buf[i])
                            pal = 0;
                    end
                    r.is_palindrome = pal;
                    r.is_semordnilap = pal ? 1'b0 : find_reversal(rev, qlen);
                    r.dictionary_overflowed = overflowed;
                    query_pos = 0;
                    pending.push_back(r);
                end
            end
            prwl_pkg::ACT_CLEAR:
            begin
                stored_total = 0;
                load_pos = 0;
            end
            default: ;
        endcase
    endfunction

    task check_result(prwl_pkg::result_t got);
        prwl_pkg::result_t want;
        results_seen++;
        if (pending.size() == 0)
        begin
            report("result with no pending query", 0, got);
            return;
        end
        want = pending.pop_front();
        if (got.is_palindrome)
            palindromes_seen++;
        if (got.is_semordnilap)
            semordnilaps_seen++;
        if (got.is_palindrome !== want.is_palindrome)
            report("is_palindrome", want.is_palindrome, got.is_palindrome);
        if (got.is_semordnilap !== want.is_semordnilap)
            report("is_semordnilap", want.is_semordnilap, got.is_semordnilap);
        if (got.dictionary_overflowed !== want.dictionary_overflowed)
            report("dictionary_overflowed", want.dictionary_overflowed,
                got.dictionary_overflowed);
    endtask

    task report(string what, logic [2:0] want, logic [2:0] got);
        errors++;
        $display("MISMATCH result %0d %s: expected %0h got %0h", results_seen, what, want, got);
    endtask
endclass

module tb_palindrome_reverse_word_lookup;
    import prwl_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    lookup_scoreboard board;
    int      items_sent;
    bit      sender_calm;     // disables random idling on the input side
    bit      receiver_calm;   // disables random stalling on the output side
    int      hold_off;        // cycles for a long receiver hold-off

    // dictionary words kept sorted for well-formed loads
    byte unsigned word_pool[$][$];

    palindrome_reverse_word_lookup i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Run limit: far beyond the slowest correct run.
    initial
    begin
        #40000000;
        $display("Timeout before all results arrived");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Send one transaction, idling at random first; hold until accepted.
    task automatic send_item(input logic [1:0] act, input byte unsigned ch, input bit last);
        item_t it;
        while (!sender_calm && $urandom_range(99) < 17)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        it.action = act;
        it.char_byte = ch;
        it.word_end = last;
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (item_stall);
        board.note_item(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_word(input logic [1:0] act, input byte unsigned w[$]);
        for (int i = 0; i < w.size(); i++)
            send_item(act, w[i], i == w.size() - 1);
    endtask

    // Random word: mostly short over a tiny alphabet so hits are common.
    function automatic void make_word(output byte unsigned w[$]);
        int n;
        w = {};
        n = ($urandom_range(19) == 0) ? $urandom_range(40, 33) : $urandom_range(6, 1);
        for (int i = 0; i < n; i++)
            w.push_back(($urandom_range(9) == 0) ? $urandom_range(255) :
                8'h61 + $urandom_range(2));
    endfunction

    function automatic bit word_less(byte unsigned a[$], byte unsigned b[$]);
        int n;
        n = (a.size() < b.size()) ? a.size() : b.size();
        if (n > 32)
            n = 32;
        for (int i = 0; i < n; i++)
            if (a[i] != b[i])
                return a[i] < b[i];
        return a.size() < b.size();
    endfunction

    // Load a fresh sorted dictionary of cnt words; keep it for queries.
    task automatic load_sorted(input int cnt);
        byte unsigned w[$];
        int pos;
        send_item(ACT_CLEAR, $urandom_range(255), $urandom_range(1));
        word_pool = {};
        for (int k = 0; k < cnt; k++)
        begin
            make_word(w);
            if (w.size() > 32)
                w = w[0:31];
            pos = 0;
            while (pos < word_pool.size() && word_less(word_pool[pos], w))
                pos++;
            word_pool.insert(pos, w);
        end
        foreach (word_pool[k])
            send_word(ACT_DICT, word_pool[k]);
    endtask

    // Query: reversal of a stored word, a palindrome, or random.
    task automatic random_query();
        byte unsigned w[$];
        byte unsigned r[$];
        int pick;
        pick = $urandom_range(9);
        if (pick < 5 && word_pool.size() > 0)
        begin
            w = word_pool[$urandom_range(word_pool.size() - 1)];
            r = {};
            foreach (w[i])
                r.push_front(w[i]);
        end
        else
        begin
            make_word(r);
            if (pick < 7)
                for (int i = r.size() - 1; i >= 0; i--)
                    r.push_back(r[i]);
        end
        send_word(ACT_QUERY, r);
    endtask

    // Result side: stall at random, check on each accepted transaction.
    initial
    begin
        result_stall = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                result_stall <= 1'b1;
                hold_off--;
            end
            else
                result_stall <= !receiver_calm && ($urandom_range(99) < 17);
        end
    end

    always @(posedge clk)
        if (rst_n && result_valid && !result_stall)
            board.check_result(result);

    initial
    begin
        byte unsigned w[$];
        int guard;
        board = new();
        items_sent = 0;
        sender_calm = 0;
        receiver_calm = 0;
        hold_off = 0;
        item_valid = 1'b0;
        item = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty dictionary, byte extremes, truncation, unused action.
        send_item(ACT_QUERY, 8'h00, 1);
        send_item(ACT_QUERY, 8'hff, 1);
        send_word(ACT_QUERY, '{8'h00, 8'hff});
        send_word(ACT_DICT, '{8'h00});
        send_word(ACT_DICT, '{8'h00, 8'hff});
        send_word(ACT_DICT, '{8'hff, 8'h00});
        send_word(ACT_QUERY, '{8'hff, 8'h00});
        send_word(ACT_QUERY, '{8'h00, 8'hff});
        send_item(ACT_UNUSED, 8'haa, 1);
        send_item(ACT_QUERY, 8'h00, 1);
        // Clear mid-word and mid-query: query keeps its bytes.
        send_item(ACT_DICT, 8'h55, 0);
        send_item(ACT_QUERY, 8'h01, 0);
        send_item(ACT_CLEAR, 8'h00, 0);
        send_item(ACT_QUERY, 8'h02, 1);
        // Long words: 40 bytes each, truncated to 32.
        w = {};
        for (int i = 0; i < 40; i++)
            w.push_back(i);
        send_word(ACT_DICT, w);
        w = {};
        for (int i = 0; i < 40; i++)
            w.push_back(31 - i);
        send_word(ACT_QUERY, w);
        // Second word, in sorted order after the long one; the query's reversal is not stored.
        send_word(ACT_DICT, '{8'h01});
        send_word(ACT_QUERY, '{8'h05, 8'h07});

        // Full dictionary: fill to capacity with one-byte words, then overflow.
        sender_calm = 1;
        receiver_calm = 1;
        send_item(ACT_CLEAR, 8'h00, 1);
        for (int k = 0; k < 1024; k++)
            send_item(ACT_DICT, k[7:0], 1);
        send_word(ACT_QUERY, '{8'h07, 8'h02});
        send_word(ACT_DICT, '{8'h12, 8'h34});
        send_word(ACT_QUERY, '{8'h00, 8'h04, 8'h09});
        send_word(ACT_QUERY, '{8'h05, 8'h00});

        // Long receiver hold-off while queries keep coming.
        hold_off = 400;
        send_word(ACT_QUERY, '{8'h01, 8'h02});
        send_word(ACT_QUERY, '{8'h03, 8'h00});
        send_word(ACT_QUERY, '{8'h09, 8'h09});
        send_word(ACT_QUERY, '{8'h04});
        sender_calm = 0;
        receiver_calm = 0;

        // Random: sorted dictionaries with queries, some noise.
        while (items_sent < 1800)
        begin
            load_sorted($urandom_range(12, 1));
            repeat ($urandom_range(12, 4))
            begin
                if ($urandom_range(9) == 0)
                    send_item($urandom_range(3), $urandom_range(255), $urandom_range(1));
                else
                    random_query();
            end
            // one stretch with no idling
            sender_calm = (items_sent > 1300 && items_sent < 1550);
            receiver_calm = sender_calm;
        end
        item_valid <= 1'b0;

        guard = 0;
        while (board.pending.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (400) @(posedge clk);
        if (board.pending.size() != 0)
        begin
            $display("%0d results never arrived", board.pending.size());
            board.errors++;
        end
        $display("Sent %0d transactions, checked %0d results (%0d palindromes, %0d reversals)",
            items_sent, board.results_seen, board.palindromes_seen, board.semordnilaps_seen);
        $display("Covered byte extremes, truncation, clears, full dictionary and output hold-off");
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
